// ----- hdl/goldbach_partition_enumerator_assert.svh -----
// Assertion macros for the checker file
`ifndef GOLDBACH_PARTITION_ENUMERATOR_ASSERT_SVH
`define GOLDBACH_PARTITION_ENUMERATOR_ASSERT_SVH

// Same-cycle implication, checked at every clock edge out of reset
`define GPE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every clock edge out of reset
`define GPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/gpe_pkg.sv -----
`timescale 1ns / 1ps
package gpe_pkg;

   // Map size and listing limit
   localparam int MAX_N      = 1024;
   localparam int MAX_LISTED = 63;

   // Field and internal widths
   localparam int NUM_W    = 12;
   localparam int ADDEND_W = 11;
   localparam int WIDE_W   = 13;
   localparam int COUNT_W  = 16;
   localparam int LIST_W   = 6;

   // Result kinds
   localparam logic [1:0] KIND_NA    = 2'd0;
   localparam logic [1:0] KIND_PART  = 2'd1;
   localparam logic [1:0] KIND_COUNT = 2'd2;

   // Classified item passed from front to back
   typedef struct packed {
      logic                neg;
      logic                na;
      logic                odd;
      logic [ADDEND_W-1:0] mag;
   } gpe_item_type;

endpackage

// ----- hdl/goldbach_partition_enumerator.sv -----
`timescale 1ns / 1ps
// A small or out-of-range number is answered straight from S_START, with no search.
// Even numbers: a read and a check state per candidate addend, up to |n|/2 candidates.
// Odd numbers: a read and a check state per candidate p, and again per (p, q) pair.
// The two-read-port prime map sets the pace; one item is searched at a time.
// Reset: synchronous; the map is rebuilt by a fill pass plus a sieve pass,
// during which items queue in a 2-entry buffer and then stall.
module goldbach_partition_enumerator
   import gpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [NUM_W-1:0]    req_number,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [ADDEND_W-1:0] rsp_first_addend,
   output logic [ADDEND_W-1:0] rsp_second_addend,
   output logic [ADDEND_W-1:0] rsp_third_addend,
   output logic [COUNT_W-1:0]  rsp_partition_count,
   output logic                rsp_truncated,
   output logic                rsp_last
);

   logic         q_valid;
   logic         q_pop;
   gpe_item_type q_item;

   gpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_number (req_number),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   gpe_engine u_engine (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_first_addend    (rsp_first_addend),
      .rsp_second_addend   (rsp_second_addend),
      .rsp_third_addend    (rsp_third_addend),
      .rsp_partition_count (rsp_partition_count),
      .rsp_truncated       (rsp_truncated),
      .rsp_last            (rsp_last)
   );

endmodule

// ----- hdl/gpe_front.sv -----
`timescale 1ns / 1ps
module gpe_front
   import gpe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [NUM_W-1:0] req_number,
   output logic             q_valid,
   output gpe_item_type     q_item,
   input  logic             q_pop
);

   gpe_item_type       entry_ff [0:1];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [NUM_W-1:0]   mag_full;
   gpe_item_type       item_new;
   logic               push;

   // Classify the incoming number
   always_comb begin
      mag_full     = req_number[NUM_W-1] ? (NUM_W'(0) - req_number) : req_number;
      item_new.neg = req_number[NUM_W-1];
      item_new.na  = (mag_full <= NUM_W'(5)) || (mag_full > NUM_W'(MAX_N));
      item_new.odd = mag_full[0];
      item_new.mag = mag_full[ADDEND_W-1:0];
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Hold queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

// ----- hdl/gpe_engine.sv -----
`timescale 1ns / 1ps
module gpe_engine
   import gpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  gpe_item_type        q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [ADDEND_W-1:0] rsp_first_addend,
   output logic [ADDEND_W-1:0] rsp_second_addend,
   output logic [ADDEND_W-1:0] rsp_third_addend,
   output logic [COUNT_W-1:0]  rsp_partition_count,
   output logic                rsp_truncated,
   output logic                rsp_last
);

   localparam logic [3:0] S_FILL    = 4'd0;
   localparam logic [3:0] S_SV_RD   = 4'd1;
   localparam logic [3:0] S_SV_CHK  = 4'd2;
   localparam logic [3:0] S_SV_MARK = 4'd3;
   localparam logic [3:0] S_SV_NEXT = 4'd4;
   localparam logic [3:0] S_IDLE    = 4'd5;
   localparam logic [3:0] S_START   = 4'd6;
   localparam logic [3:0] S_E_RD    = 4'd7;
   localparam logic [3:0] S_E_CHK   = 4'd8;
   localparam logic [3:0] S_O_P     = 4'd9;
   localparam logic [3:0] S_O_PCHK  = 4'd10;
   localparam logic [3:0] S_O_Q     = 4'd11;
   localparam logic [3:0] S_O_QCHK  = 4'd12;
   localparam logic [3:0] S_FINAL   = 4'd13;

   logic                 map_mem [0:MAX_N];

   logic [3:0]           state_ff, state_in;
   gpe_item_type         item_ff, item_in;
   logic [ADDEND_W-1:0]  p_ff, p_in;
   logic [ADDEND_W-1:0]  q_ff, q_in;
   logic [NUM_W-1:0]     k_ff, k_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [LIST_W-1:0]    emitted_ff, emitted_in;
   logic                 rd_a_ff, rd_b_ff;

   logic                 rd_a_en, rd_b_en;
   logic [ADDEND_W-1:0]  addr_a, addr_b;
   logic                 wr_en, wr_data;
   logic [ADDEND_W-1:0]  wr_addr;

   logic                 can_emit, emit;
   logic [1:0]           e_kind;
   logic [ADDEND_W-1:0]  e_a, e_b, e_c;
   logic [COUNT_W-1:0]   e_count;
   logic                 e_trunc, e_last;

   logic                 hit, listing;
   logic [2*NUM_W-1:0]   p_sq;
   logic [NUM_W-1:0]     p_next;
   logic [WIDE_W-1:0]    p3, p2q;

   assign can_emit = !rsp_valid || rsp_ready;
   assign hit      = rd_a_ff && rd_b_ff;
   assign listing  = item_ff.neg && (emitted_ff < LIST_W'(MAX_LISTED));
   assign p_next   = {1'b0, p_ff} + NUM_W'(1);
   assign p_sq     = p_next * p_next;
   assign p3       = WIDE_W'(p_ff) + WIDE_W'(p_ff) + WIDE_W'(p_ff);
   assign p2q      = WIDE_W'(p_ff) + WIDE_W'(q_ff) + WIDE_W'(q_ff);

   // Sequence the sieve build and the partition search
   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      k_in       = k_ff;
      count_in   = count_ff;
      emitted_in = emitted_ff;
      rd_a_en    = 1'b0;
      rd_b_en    = 1'b0;
      addr_a     = p_ff;
      addr_b     = item_ff.mag - p_ff;
      wr_en      = 1'b0;
      wr_addr    = k_ff[ADDEND_W-1:0];
      wr_data    = 1'b0;
      q_pop      = 1'b0;
      emit       = 1'b0;
      e_kind     = KIND_NA;
      e_a        = '0;
      e_b        = '0;
      e_c        = '0;
      e_count    = '0;
      e_trunc    = 1'b0;
      e_last     = 1'b0;
      case (state_ff)
         S_FILL: begin
            wr_en   = 1'b1;
            wr_data = (k_ff >= NUM_W'(2));
            if (k_ff == NUM_W'(MAX_N)) begin
               p_in     = ADDEND_W'(2);
               state_in = S_SV_RD;
            end else begin
               k_in = k_ff + NUM_W'(1);
            end
         end
         S_SV_RD: begin
            rd_a_en  = 1'b1;
            state_in = S_SV_CHK;
         end
         S_SV_CHK: begin
            if (rd_a_ff) begin
               k_in     = {1'b0, p_ff} + {1'b0, p_ff};
               state_in = S_SV_MARK;
            end else begin
               state_in = S_SV_NEXT;
            end
         end
         S_SV_MARK: begin
            wr_en = 1'b1;
            if ((k_ff + {1'b0, p_ff}) > NUM_W'(MAX_N)) begin
               state_in = S_SV_NEXT;
            end else begin
               k_in = k_ff + {1'b0, p_ff};
            end
         end
         S_SV_NEXT: begin
            if (p_sq > (2*NUM_W)'(MAX_N)) begin
               state_in = S_IDLE;
            end else begin
               p_in     = p_next[ADDEND_W-1:0];
               state_in = S_SV_RD;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               item_in    = q_item;
               p_in       = ADDEND_W'(2);
               count_in   = '0;
               emitted_in = '0;
               state_in   = S_START;
            end
         end
         S_START: begin
            if (item_ff.na) begin
               if (can_emit) begin
                  emit     = 1'b1;
                  e_last   = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (item_ff.odd) begin
               state_in = S_O_P;
            end else begin
               state_in = S_E_RD;
            end
         end
         S_E_RD: begin
            if (p_ff > (item_ff.mag >> 1)) begin
               state_in = S_FINAL;
            end else begin
               rd_a_en  = 1'b1;
               rd_b_en  = 1'b1;
               state_in = S_E_CHK;
            end
         end
         S_E_CHK: begin
            if (!(hit && listing && !can_emit)) begin
               if (hit) begin
                  if (count_ff != '1) count_in = count_ff + COUNT_W'(1);
                  if (listing) begin
                     emit       = 1'b1;
                     e_kind     = KIND_PART;
                     e_a        = p_ff;
                     e_b        = item_ff.mag - p_ff;
                     emitted_in = emitted_ff + LIST_W'(1);
                  end
               end
               p_in     = p_ff + ADDEND_W'(1);
               state_in = S_E_RD;
            end
         end
         S_O_P: begin
            if (p3 > WIDE_W'(item_ff.mag)) begin
               state_in = S_FINAL;
            end else begin
               rd_a_en  = 1'b1;
               state_in = S_O_PCHK;
            end
         end
         S_O_PCHK: begin
            if (rd_a_ff) begin
               q_in     = p_ff;
               state_in = S_O_Q;
            end else begin
               p_in     = p_ff + ADDEND_W'(1);
               state_in = S_O_P;
            end
         end
         S_O_Q: begin
            addr_a = q_ff;
            addr_b = item_ff.mag - p_ff - q_ff;
            if (p2q > WIDE_W'(item_ff.mag)) begin
               p_in     = p_ff + ADDEND_W'(1);
               state_in = S_O_P;
            end else begin
               rd_a_en  = 1'b1;
               rd_b_en  = 1'b1;
               state_in = S_O_QCHK;
            end
         end
         S_O_QCHK: begin
            if (!(hit && listing && !can_emit)) begin
               if (hit) begin
                  if (count_ff != '1) count_in = count_ff + COUNT_W'(1);
                  if (listing) begin
                     emit       = 1'b1;
                     e_kind     = KIND_PART;
                     e_a        = p_ff;
                     e_b        = q_ff;
                     e_c        = item_ff.mag - p_ff - q_ff;
                     emitted_in = emitted_ff + LIST_W'(1);
                  end
               end
               q_in     = q_ff + ADDEND_W'(1);
               state_in = S_O_Q;
            end
         end
         S_FINAL: begin
            if (can_emit) begin
               emit     = 1'b1;
               e_kind   = KIND_COUNT;
               e_count  = count_ff;
               e_trunc  = item_ff.neg && (count_ff > COUNT_W'(MAX_LISTED));
               e_last   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_FILL;
         k_ff      <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         if (emit) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   // Hold working payload
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      count_ff   <= count_in;
      emitted_ff <= emitted_in;
      if (emit) begin
         rsp_kind            <= e_kind;
         rsp_first_addend    <= e_a;
         rsp_second_addend   <= e_b;
         rsp_third_addend    <= e_c;
         rsp_partition_count <= e_count;
         rsp_truncated       <= e_trunc;
         rsp_last            <= e_last;
      end
   end

   // Prime map: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= map_mem[addr_a];
      end
      if (rd_b_en) begin
         rd_b_ff <= map_mem[addr_b];
      end
   end

endmodule

// ----- hdl/gpe_checker.sv -----
`timescale 1ns / 1ps
`include "goldbach_partition_enumerator_assert.svh"
module gpe_checker
   import gpe_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [NUM_W-1:0]    req_number,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [1:0]          rsp_kind,
   input logic [ADDEND_W-1:0] rsp_first_addend,
   input logic [ADDEND_W-1:0] rsp_second_addend,
   input logic [ADDEND_W-1:0] rsp_third_addend,
   input logic [COUNT_W-1:0]  rsp_partition_count,
   input logic                rsp_truncated,
   input logic                rsp_last
);

   // A stalled request holds
   `GPE_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready,
      req_valid && $stable(req_number))

   // A stalled result holds
   `GPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_first_addend) &&
      $stable(rsp_second_addend) && $stable(rsp_third_addend) &&
      $stable(rsp_partition_count) && $stable(rsp_truncated) && $stable(rsp_last))

   // A not-applicable answer closes its item
   `GPE_ASSERT_NOW(a_na_last, clock, reset, rsp_valid && rsp_kind == KIND_NA,
      rsp_last && rsp_partition_count == '0 && !rsp_truncated)

   // A listed partition never closes and carries no count
   `GPE_ASSERT_NOW(a_part_open, clock, reset, rsp_valid && rsp_kind == KIND_PART,
      !rsp_last && rsp_partition_count == '0 && rsp_first_addend != '0)

   // A count closes and carries no first or third addend
   `GPE_ASSERT_NOW(a_count_last, clock, reset, rsp_valid && rsp_kind == KIND_COUNT,
      rsp_last && rsp_first_addend == '0 && rsp_third_addend == '0)

endmodule

bind goldbach_partition_enumerator gpe_checker u_gpe_checker (.*);

// ----- tb/gpe_checker.sv -----
`timescale 1ns / 1ps
module gpe_monitor
   import gpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [NUM_W-1:0]    req_number,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [1:0]          rsp_kind,
   input  logic [ADDEND_W-1:0] rsp_first_addend,
   input  logic [ADDEND_W-1:0] rsp_second_addend,
   input  logic [ADDEND_W-1:0] rsp_third_addend,
   input  logic [COUNT_W-1:0]  rsp_partition_count,
   input  logic                rsp_truncated,
   input  logic                rsp_last,
   output int                  fail_count,
   output int                  pending
);

   typedef struct {
      logic [1:0]          kind;
      logic [ADDEND_W-1:0] first;
      logic [ADDEND_W-1:0] second;
      logic [ADDEND_W-1:0] third;
      logic [COUNT_W-1:0]  count;
      logic                trunc;
      logic                last;
   } partition_rsp_type;

   bit                is_prime [0:MAX_N];
   partition_rsp_type partitions_due [$];

   // Build the primality map by trial division
   initial begin
      for (int k = 0; k <= MAX_N; k++) begin
         is_prime[k] = (k >= 2);
         for (int d = 2; d * d <= k; d++) begin
            if (k % d == 0) is_prime[k] = 0;
         end
      end
   end

   function automatic bit prime_at(int k);
      if (k < 0 || k > MAX_N) return 0;
      return is_prime[k];
   endfunction

   task automatic push_rsp(logic [1:0] kind, int a, int b, int c, int cnt, bit tr, bit lst);
      partition_rsp_type r;
      r.kind   = kind;
      r.first  = a[ADDEND_W-1:0];
      r.second = b[ADDEND_W-1:0];
      r.third  = c[ADDEND_W-1:0];
      r.count  = cnt[COUNT_W-1:0];
      r.trunc  = tr;
      r.last   = lst;
      partitions_due.push_back(r);
   endtask

   // Enumerate the partitions of one accepted number
   task automatic predict_partitions(logic [NUM_W-1:0] raw);
      bit neg;
      int mag;
      int count;
      int listed;
      neg    = raw[NUM_W-1];
      mag    = neg ? (4096 - int'(raw)) : int'(raw);
      count  = 0;
      listed = 0;
      if (mag <= 5 || mag > MAX_N) begin
         push_rsp(KIND_NA, 0, 0, 0, 0, 0, 1);
         return;
      end
      if (mag % 2 == 0) begin
         for (int p = 2; p <= mag / 2; p++) begin
            if (prime_at(p) && prime_at(mag - p)) begin
               if (neg && listed < MAX_LISTED) begin
                  push_rsp(KIND_PART, p, mag - p, 0, 0, 0, 0);
                  listed++;
               end
               count++;
            end
         end
      end else begin
         for (int p = 2; 3 * p <= mag; p++) begin
            if (!prime_at(p)) continue;
            for (int q = p; p + 2 * q <= mag; q++) begin
               if (prime_at(q) && prime_at(mag - p - q)) begin
                  if (neg && listed < MAX_LISTED) begin
                     push_rsp(KIND_PART, p, q, mag - p - q, 0, 0, 0);
                     listed++;
                  end
                  count++;
               end
            end
         end
      end
      push_rsp(KIND_COUNT, 0, 0, 0, (count > 65535) ? 65535 : count,
               neg && count > MAX_LISTED, 1);
   endtask

   // Predict on each input transfer, compare on each result transfer
   always @(posedge clock) begin
      partition_rsp_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) predict_partitions(req_number);
         if (rsp_valid && rsp_ready) begin
            if (partitions_due.size() == 0) begin
               $error("unexpected result transfer: kind %0d", rsp_kind);
               fail_count <= fail_count + 1;
            end else begin
               e = partitions_due.pop_front();
               if (rsp_kind !== e.kind || rsp_first_addend !== e.first ||
                   rsp_second_addend !== e.second || rsp_third_addend !== e.third ||
                   rsp_partition_count !== e.count || rsp_truncated !== e.trunc ||
                   rsp_last !== e.last) begin
                  if (rsp_kind !== e.kind)
                     $error("kind: expected %0d, actual %0d", e.kind, rsp_kind);
                  if (rsp_first_addend !== e.first)
                     $error("first_addend: expected %0d, actual %0d", e.first,
                            rsp_first_addend);
                  if (rsp_second_addend !== e.second)
                     $error("second_addend: expected %0d, actual %0d", e.second,
                            rsp_second_addend);
                  if (rsp_third_addend !== e.third)
                     $error("third_addend: expected %0d, actual %0d", e.third,
                            rsp_third_addend);
                  if (rsp_partition_count !== e.count)
                     $error("partition_count: expected %0d, actual %0d", e.count,
                            rsp_partition_count);
                  if (rsp_truncated !== e.trunc)
                     $error("truncated: expected %0d, actual %0d", e.trunc, rsp_truncated);
                  if (rsp_last !== e.last)
                     $error("last: expected %0d, actual %0d", e.last, rsp_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= partitions_due.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import gpe_pkg::*;

   localparam int IDLE_LIMIT = 200000;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_ready;
   logic [NUM_W-1:0]    req_number = '0;
   logic                rsp_valid;
   logic                rsp_ready = 0;
   logic [1:0]          rsp_kind;
   logic [ADDEND_W-1:0] rsp_first_addend;
   logic [ADDEND_W-1:0] rsp_second_addend;
   logic [ADDEND_W-1:0] rsp_third_addend;
   logic [COUNT_W-1:0]  rsp_partition_count;
   logic                rsp_truncated;
   logic                rsp_last;
   int                  fail_count;
   int                  pending;
   bit                  hold_req = 0;
   bit                  hold_done = 0;
   int                  idle_cycles = 0;

   always #5 clock = ~clock;

   goldbach_partition_enumerator u_top (.*);

   gpe_monitor u_checker (.*);

   // Draw a gap length: mostly short, a few long
   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 4);
   endfunction

   // Offer one number and hold it until the transfer
   task automatic send_number(logic [NUM_W-1:0] v);
      bit rdy;
      req_valid  <= 1;
      req_number <= v;
      forever begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
         if (rdy) break;
      end
   endtask

   task automatic send_gap();
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Mostly small magnitudes to keep searches short, with some full-width patterns
   function automatic logic [NUM_W-1:0] pick_number();
      int m;
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return NUM_W'($urandom);
      if (r == 2) m = $urandom_range(600, 1024);
      else m = $urandom_range(0, 160);
      return $urandom_range(0, 1) ? NUM_W'(-m) : NUM_W'(m);
   endfunction

   // Result side: random backpressure, with a long hold-off on request
   initial begin
      int g;
      forever begin
         if (hold_req && !hold_done) begin
            rsp_ready <= 0;
            repeat (3000) @(posedge clock);
            hold_done = 1;
         end else begin
            g = gap_len();
            rsp_ready <= (g == 0) || ($urandom_range(0, 3) != 0);
            repeat (g + 1) @(posedge clock);
         end
      end
   end

   // Watchdog: end the run if nothing transfers for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int directed [] = '{0, 1, 5, -5, 6, -6, 7, -7, 8, -9, 11, 2, -1, 100, -101,
                          1024, -1024, 1025, -1025, 2047, -2048, -1000, -1023, 1023};
      repeat (2) @(posedge clock);
      reset <= 0;
      foreach (directed[i]) begin
         send_number(NUM_W'(directed[i]));
         send_gap();
      end
      // Fill the block while the receiver holds off
      hold_req = 1;
      for (int i = 0; i < 10; i++) send_number(NUM_W'(-(40 + 2 * i)));
      req_valid <= 0;
      // Pause until everything is back
      @(posedge clock);
      while (pending != 0 || !hold_done) @(posedge clock);
      repeat (20) @(posedge clock);
      for (int i = 0; i < 70; i++) begin
         send_number(pick_number());
         send_gap();
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
